// ===== hdl/frpr_pkg.sv =====
// Shared types and constants for the fit/rotate placement rectangle unit.
package frpr_pkg;

    localparam int DIM_W  = 14;
    localparam int ZOOM_W = 24;
    localparam int ANCH_W = 17;
    localparam int ROT_W  = 16;
    localparam int POS_W  = 40;
    localparam int SPAN_W = 39;

    localparam logic [1:0] MODE_FIT     = 2'd0;
    localparam logic [1:0] MODE_COVER   = 2'd1;
    localparam logic [1:0] MODE_STRETCH = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    localparam logic [1:0] REG_DEST_W   = 2'd0;
    localparam logic [1:0] REG_DEST_H   = 2'd1;
    localparam logic [1:0] REG_CANVAS_W = 2'd2;
    localparam logic [1:0] REG_CANVAS_H = 2'd3;

    localparam logic [DIM_W-1:0]  DEST_W_RST = 14'd1920;
    localparam logic [DIM_W-1:0]  DEST_H_RST = 14'd1080;
    localparam logic [ZOOM_W-1:0] ZOOM_MIN   = 24'd66;

    // floor(x/90) == (x * 46604) >> 22 for 0 <= x <= 32768
    localparam logic [16:0] ROT_RECIP = 17'd46604;
    localparam int          ROT_SHIFT = 22;

    localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

    typedef struct packed {
        logic [ANCH_W-1:0] ax;
        logic [ANCH_W-1:0] ay;
        logic [1:0]        turns;
        logic              fx;
        logic              fy;
    } t_side;

endpackage

// ===== hdl/fit_rotate_placement_rect_unit.sv =====
// Placement rectangle pipeline: rotation, fit ratio, pipelined division, anchoring.
//
//   channel | ports                                    | handshake
//   --------+------------------------------------------+-------------------------------
//   request | i_source_*, i_mode, i_rotation_degrees.. | i_start & !o_busy
//   result  | o_rect_*, o_quarter_turns, o_flip_*      | o_valid, one cycle, no stall
//   config  | i_cfg_idx, i_cfg_data                    | i_cfg_we
//
// One request per cycle; the pipeline has 5 + 41 + 3 = 49 register stages (the 41-stage
// restoring divider dominates). o_busy is never asserted. Synchronous active-low reset
// clears the valid chain and restores the size registers. The result side cannot stall,
// so the pipeline simply advances every cycle.
module fit_rotate_placement_rect_unit
    import frpr_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [DIM_W-1:0]         i_cfg_data,
    input  logic [DIM_W-1:0]         i_source_width,
    input  logic [DIM_W-1:0]         i_source_height,
    input  logic [1:0]               i_mode,
    input  logic signed [ROT_W-1:0]  i_rotation_degrees,
    input  logic [ZOOM_W-1:0]        i_zoom,
    input  logic [ANCH_W-1:0]        i_anchor_horizontal,
    input  logic [ANCH_W-1:0]        i_anchor_vertical,
    input  logic                     i_mirror_horizontal,
    input  logic                     i_mirror_vertical,
    output logic                     o_valid,
    output logic signed [POS_W-1:0]  o_rect_left,
    output logic signed [POS_W-1:0]  o_rect_top,
    output logic [SPAN_W-1:0]        o_rect_span_x,
    output logic [SPAN_W-1:0]        o_rect_span_y,
    output logic [1:0]               o_quarter_turns,
    output logic                     o_flip_x_out,
    output logic                     o_flip_y_out
);

    localparam int PW = 2 * DIM_W;          // ratio terms
    localparam int NW = PW + ZOOM_W;        // numerator before scaling
    localparam int BW = PW + 16;            // divisor
    localparam int QW = SPAN_W + 2;         // quotient incl. round bit and overflow margin
    localparam int RW = BW + QW;            // remainder
    localparam int AW = NW + FRACTION_BITS + 1;
    localparam int PL = 20;                 // low slice for the anchor product

    // configuration
    logic [DIM_W-1:0] r_dest_w, r_dest_h, r_canvas_w, r_canvas_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_w   <= DEST_W_RST;
            r_dest_h   <= DEST_H_RST;
            r_canvas_w <= DEST_W_RST;
            r_canvas_h <= DEST_H_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEST_W:   r_dest_w   <= i_cfg_data;
                REG_DEST_H:   r_dest_h   <= i_cfg_data;
                REG_CANVAS_W: r_canvas_w <= i_cfg_data;
                REG_CANVAS_H: r_canvas_h <= i_cfg_data;
                default:      r_dest_w   <= r_dest_w;
            endcase
        end
    end

    logic [DIM_W-1:0] w_w, w_h, w_lw, w_lh;
    assign w_w  = (r_dest_w   == '0) ? DIM_W'(1) : r_dest_w;
    assign w_h  = (r_dest_h   == '0) ? DIM_W'(1) : r_dest_h;
    assign w_lw = (r_canvas_w == '0) ? DIM_W'(1) : r_canvas_w;
    assign w_lh = (r_canvas_h == '0) ? DIM_W'(1) : r_canvas_h;

    assign o_busy = 1'b0;

    // ---------------- stage 1: quarter turns, zoom clamp ----------------
    logic [16:0] n_rmag;
    logic [33:0] n_rprod;
    logic [11:0] n_rq;
    logic [1:0]  n_turns;

    assign n_rmag  = i_rotation_degrees[ROT_W-1] ? (17'd0 - {1'b1, i_rotation_degrees})
                                                  : {1'b0, i_rotation_degrees};
    assign n_rprod = n_rmag * ROT_RECIP;
    assign n_rq    = n_rprod[ROT_SHIFT +: 12];
    assign n_turns = i_rotation_degrees[ROT_W-1] ? 2'(2'd0 - n_rq[1:0]) : n_rq[1:0];

    logic              r1_vld;
    logic [DIM_W-1:0]  r1_sw, r1_sh;
    logic [1:0]        r1_mode;
    logic [ZOOM_W-1:0] r1_zoom;
    t_side             r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else          r1_vld <= i_start;
        r1_sw         <= i_source_width;
        r1_sh         <= i_source_height;
        r1_mode       <= i_mode;
        r1_zoom       <= (i_zoom < ZOOM_MIN) ? ZOOM_MIN : i_zoom;
        r1_side.ax    <= i_anchor_horizontal;
        r1_side.ay    <= i_anchor_vertical;
        r1_side.turns <= n_turns;
        r1_side.fx    <= i_mirror_horizontal;
        r1_side.fy    <= i_mirror_vertical;
    end

    // ---------------- stage 2: swap, cross products ----------------
    logic [DIM_W-1:0] n_esw, n_esh;
    assign n_esw = r1_side.turns[0] ? r1_sh : r1_sw;
    assign n_esh = r1_side.turns[0] ? r1_sw : r1_sh;

    logic              r2_vld, r2_fill;
    logic [1:0]        r2_mode;
    logic [DIM_W-1:0]  r2_esw, r2_esh;
    logic [PW-1:0]     r2_wesh, r2_hesw;
    logic [ZOOM_W-1:0] r2_zoom;
    t_side             r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else          r2_vld <= r1_vld;
        r2_fill <= (r1_sw == '0) || (r1_sh == '0) || (r1_mode == MODE_STRETCH);
        r2_mode <= r1_mode;
        r2_esw  <= n_esw;
        r2_esh  <= n_esh;
        r2_wesh <= w_w * n_esh;
        r2_hesw <= w_h * n_esw;
        r2_zoom <= r1_zoom;
        r2_side <= r1_side;
    end

    // ---------------- stage 3: ratio selection ----------------
    logic          n_bound;
    logic [PW-1:0] n_nx, n_dx, n_ny, n_dy;

    always_comb begin
        n_bound = (r2_mode == MODE_FIT) ? (r2_wesh <= r2_hesw) : (r2_wesh >= r2_hesw);
        n_nx = PW'(1);
        n_dx = PW'(1);
        n_ny = PW'(1);
        n_dy = PW'(1);
        if (r2_fill) begin
            n_nx = PW'(1);
        end else if (r2_mode == MODE_NONE) begin
            n_nx = PW'(r2_esw);
            n_dx = PW'(w_lw);
            n_ny = PW'(r2_esh);
            n_dy = PW'(w_lh);
        end else if (n_bound) begin
            n_ny = r2_wesh;
            n_dy = r2_hesw;
        end else begin
            n_nx = r2_hesw;
            n_dx = r2_wesh;
        end
    end

    logic              r3_vld;
    logic [PW-1:0]     r3_n [2];
    logic [PW-1:0]     r3_d [2];
    logic [ZOOM_W-1:0] r3_zoom;
    t_side             r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else          r3_vld <= r2_vld;
        r3_n[0] <= n_nx;
        r3_d[0] <= n_dx;
        r3_n[1] <= n_ny;
        r3_d[1] <= n_dy;
        r3_zoom <= r2_zoom;
        r3_side <= r2_side;
    end

    // ---------------- stage 4: numerator product ----------------
    logic          r4_vld;
    logic [NW-1:0] r4_n [2];
    logic [PW-1:0] r4_d [2];
    t_side         r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else          r4_vld <= r3_vld;
        for (int l = 0; l < 2; l++) begin
            r4_n[l] <= r3_n[l] * r3_zoom;
            r4_d[l] <= r3_d[l];
        end
        r4_side <= r3_side;
    end

    // ---------------- stage 5: scale, overflow check ----------------
    // dividend = N * 2^(F+1), divisor = D * 2^16; quotient carries one round bit
    logic [RW-1:0] r_rem [0:QW][2];
    logic [QW-1:0] r_quo [0:QW][2];
    logic [BW-1:0] r_dv  [0:QW][2];
    logic          r_ovf [0:QW][2];
    t_side         r_dside [0:QW];
    logic          r_dvld  [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dvld[0] <= 1'b0;
        else          r_dvld[0] <= r4_vld;
        for (int l = 0; l < 2; l++) begin
            r_rem[0][l] <= RW'({r4_n[l], {(FRACTION_BITS + 1){1'b0}}});
            r_dv[0][l]  <= {r4_d[l], 16'd0};
            r_quo[0][l] <= '0;
            r_ovf[0][l] <= RW'(AW'({r4_n[l], {(FRACTION_BITS + 1){1'b0}}}))
                           >= {r4_d[l], 16'd0, {QW{1'b0}}};
        end
        r_dside[0] <= r4_side;
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [RW-1:0] n_sub [2];
        logic [RW-1:0] n_rem [2];
        logic          n_bit [2];

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                n_sub[l] = RW'(r_dv[k][l]) << (QW - 1 - k);
                n_bit[l] = r_rem[k][l] >= n_sub[l];
                n_rem[l] = n_bit[l] ? (r_rem[k][l] - n_sub[l]) : r_rem[k][l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dvld[k+1] <= 1'b0;
            else          r_dvld[k+1] <= r_dvld[k];
            for (int l = 0; l < 2; l++) begin
                r_rem[k+1][l] <= n_rem[l];
                r_dv[k+1][l]  <= r_dv[k][l];
                r_ovf[k+1][l] <= r_ovf[k][l];
                r_quo[k+1][l] <= r_quo[k][l] | (QW'(n_bit[l]) << (QW - 1 - k));
            end
            r_dside[k+1] <= r_dside[k];
        end
    end

    // ---------------- round, saturate, edge offset ----------------
    logic [QW-1:0]     n_rnd [2];
    logic [SPAN_W-1:0] n_span [2];
    logic [SPAN_W-1:0] w_one;

    assign w_one = SPAN_W'(1) << FRACTION_BITS;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_rnd[l] = QW'(({1'b0, r_quo[QW][l]} + (QW + 1)'(1)) >> 1);
            if (r_ovf[QW][l] || (n_rnd[l] > QW'(SPAN_MAX))) n_span[l] = SPAN_MAX;
            else                                            n_span[l] = n_rnd[l][SPAN_W-1:0];
        end
    end

    logic              r6_vld;
    logic [SPAN_W-1:0] r6_span [2];
    logic [SPAN_W-1:0] r6_diff [2];
    logic              r6_neg  [2];
    t_side             r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_vld <= 1'b0;
        else          r6_vld <= r_dvld[QW];
        for (int l = 0; l < 2; l++) begin
            r6_span[l] <= n_span[l];
            r6_neg[l]  <= n_span[l] > w_one;
            r6_diff[l] <= (n_span[l] > w_one) ? (n_span[l] - w_one) : (w_one - n_span[l]);
        end
        r6_side <= r_dside[QW];
    end

    // anchor product in two slices
    logic                       r7_vld;
    logic [ANCH_W+PL-1:0]       r7_pl [2];
    logic [ANCH_W+SPAN_W-PL-1:0] r7_ph [2];
    logic [SPAN_W-1:0]          r7_span [2];
    logic                       r7_neg  [2];
    t_side                      r7_side;
    logic [ANCH_W-1:0]          w_anch [2];

    assign w_anch[0] = r6_side.ax;
    assign w_anch[1] = r6_side.ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_vld <= 1'b0;
        else          r7_vld <= r6_vld;
        for (int l = 0; l < 2; l++) begin
            r7_pl[l]   <= w_anch[l] * r6_diff[l][PL-1:0];
            r7_ph[l]   <= w_anch[l] * r6_diff[l][SPAN_W-1:PL];
            r7_span[l] <= r6_span[l];
            r7_neg[l]  <= r6_neg[l];
        end
        r7_side <= r6_side;
    end

    localparam int MW = ANCH_W + SPAN_W + 1;
    logic [MW-1:0]    n_prod [2];
    logic [MW-17:0]   n_mag  [2];
    logic [POS_W-1:0] n_pos  [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_prod[l] = MW'(r7_pl[l]) + (MW'(r7_ph[l]) << PL) + MW'(32768);
            n_mag[l]  = n_prod[l][MW-1:16];
            if (r7_neg[l]) begin
                if (n_mag[l] > (MW - 16)'(SPAN_MAX) + (MW - 16)'(1))
                    n_pos[l] = {1'b1, {SPAN_W{1'b0}}};
                else
                    n_pos[l] = POS_W'((MW - 16)'(0) - n_mag[l]);
            end else begin
                if (n_mag[l] > (MW - 16)'(SPAN_MAX)) n_pos[l] = POS_W'(SPAN_MAX);
                else                                 n_pos[l] = POS_W'(n_mag[l]);
            end
        end
    end

    logic              r_out_vld;
    logic [POS_W-1:0]  r_left, r_top;
    logic [SPAN_W-1:0] r_spx, r_spy;
    t_side             r_oside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else          r_out_vld <= r7_vld;
        r_left  <= n_pos[0];
        r_top   <= n_pos[1];
        r_spx   <= r7_span[0];
        r_spy   <= r7_span[1];
        r_oside <= r7_side;
    end

    assign o_valid         = r_out_vld;
    assign o_rect_left     = r_left;
    assign o_rect_top      = r_top;
    assign o_rect_span_x   = r_spx;
    assign o_rect_span_y   = r_spy;
    assign o_quarter_turns = r_oside.turns;
    assign o_flip_x_out    = r_oside.fx;
    assign o_flip_y_out    = r_oside.fy;

endmodule
